// File: hdl/linked_cell_neighbour_search_top_defines.svh
// Assertion macros shared by the checker.
`ifndef LINKED_CELL_NEIGHBOUR_SEARCH_TOP_DEFINES_SVH
`define LINKED_CELL_NEIGHBOUR_SEARCH_TOP_DEFINES_SVH

// Same-cycle implication, masked during reset.
`define LCNS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lcns assertion failed");

// Next-cycle implication, masked during reset.
`define LCNS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lcns assertion failed");

// Next-cycle implication that also holds across reset.
`define LCNS_ASSERT_RST(label, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("lcns assertion failed");

`endif

// File: hdl/lcns_pkg.sv
package lcns_pkg;

  localparam int ITEM_W  = 10;
  localparam int POS_W   = 20;
  localparam int CS_W    = 16;
  localparam int CNT_W   = 7;
  localparam int R2_W    = 32;
  localparam int CFG_W   = 32;
  localparam int IDX_W   = 3;
  localparam int COL_W   = 6;
  localparam int CELL_W  = 2 * COL_W;
  localparam int STEP_W  = 11;
  localparam int NB_W    = 7;
  localparam int DIV_CW  = 5;

  localparam logic [CNT_W-1:0]  MAX_COLS   = 7'd64;
  localparam logic [CNT_W-1:0]  MAX_ROWS   = 7'd64;
  localparam logic [NB_W-1:0]   CAP_LAST   = 7'd63;
  localparam logic [DIV_CW-1:0] DIV_LAST   = 5'd19;
  localparam logic [CELL_W-1:0] SWEEP_LAST = 12'd4095;

  localparam logic [1:0] OP_CLEAR  = 2'd0;
  localparam logic [1:0] OP_INSERT = 2'd1;
  localparam logic [1:0] OP_QUERY  = 2'd2;

  localparam logic [IDX_W-1:0] REG_ORIGIN_X  = 3'd0;
  localparam logic [IDX_W-1:0] REG_ORIGIN_Y  = 3'd1;
  localparam logic [IDX_W-1:0] REG_CELL_SIZE = 3'd2;
  localparam logic [IDX_W-1:0] REG_ACROSS    = 3'd3;
  localparam logic [IDX_W-1:0] REG_DOWN      = 3'd4;
  localparam logic [IDX_W-1:0] REG_RADIUS_SQ = 3'd5;

  localparam logic [1:0] OUT_ACK  = 2'd0;
  localparam logic [1:0] OUT_PEND = 2'd1;
  localparam logic [1:0] OUT_FIN  = 2'd2;

  typedef struct packed {
    logic       load;
    logic       sweep;
    logic       div_step;
    logic       bin;
    logic       cell_next;
    logic       head_load;
    logic       data_load;
    logic       hit_take;
    logic       head_wr;
    logic       out_load;
    logic [1:0] out_sel;
  } lcns_cmd_t;

  typedef struct packed {
    logic       sweep_done;
    logic       div_last;
    logic       cell_ok;
    logic       cell_last;
    logic       link_ok;
    logic       hit;
    logic       cap_next;
    logic       out_free;
    logic       pend_v;
    logic [1:0] op;
  } lcns_stat_t;

endpackage

// File: hdl/lcns_ctrl.sv
module lcns_ctrl
  import lcns_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic [1:0] in_operation,
  output logic       in_ready,
  input  lcns_stat_t stat,
  output lcns_cmd_t  cmd
);

  localparam logic [3:0] S_SWEEP = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_ACK   = 4'd2;
  localparam logic [3:0] S_DIV   = 4'd3;
  localparam logic [3:0] S_BIN   = 4'd4;
  localparam logic [3:0] S_IHEAD = 4'd5;
  localparam logic [3:0] S_IWR   = 4'd6;
  localparam logic [3:0] S_CELL  = 4'd7;
  localparam logic [3:0] S_HEAD  = 4'd8;
  localparam logic [3:0] S_LINK  = 4'd9;
  localparam logic [3:0] S_DATA  = 4'd10;
  localparam logic [3:0] S_CMP   = 4'd11;
  localparam logic [3:0] S_FIN   = 4'd12;

  logic [3:0] state_r, state_nxt;
  logic       clr_ack_r, clr_ack_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt   = state_r;
    clr_ack_nxt = clr_ack_r;
    cmd         = '0;
    case (state_r)
      S_SWEEP: begin
        cmd.sweep = 1'b1;
        if (stat.sweep_done) begin
          state_nxt = clr_ack_r ? S_ACK : S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          case (in_operation)
            OP_CLEAR: begin
              state_nxt   = S_SWEEP;
              clr_ack_nxt = 1'b1;
            end
            OP_INSERT, OP_QUERY: state_nxt = S_DIV;
            default:             state_nxt = S_ACK;
          endcase
        end
      end
      S_ACK: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_sel  = OUT_ACK;
          clr_ack_nxt  = 1'b0;
          state_nxt    = S_IDLE;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) begin
          state_nxt = S_BIN;
        end
      end
      S_BIN: begin
        cmd.bin   = 1'b1;
        state_nxt = (stat.op == OP_INSERT) ? S_IHEAD : S_CELL;
      end
      S_IHEAD: state_nxt = S_IWR;
      S_IWR: begin
        cmd.head_wr = 1'b1;
        state_nxt   = S_ACK;
      end
      S_CELL: begin
        if (stat.cell_ok) begin
          state_nxt = S_HEAD;
        end else if (stat.cell_last) begin
          state_nxt = S_FIN;
        end else begin
          cmd.cell_next = 1'b1;
        end
      end
      S_HEAD: begin
        cmd.head_load = 1'b1;
        state_nxt     = S_LINK;
      end
      S_LINK: begin
        if (stat.link_ok) begin
          state_nxt = S_DATA;
        end else if (stat.cell_last) begin
          state_nxt = S_FIN;
        end else begin
          cmd.cell_next = 1'b1;
          state_nxt     = S_CELL;
        end
      end
      S_DATA: begin
        cmd.data_load = 1'b1;
        state_nxt     = S_CMP;
      end
      S_CMP: begin
        if (!stat.hit) begin
          state_nxt = S_LINK;
        end else if (!stat.pend_v || stat.out_free) begin
          cmd.hit_take = 1'b1;
          cmd.out_load = stat.pend_v;
          cmd.out_sel  = OUT_PEND;
          state_nxt    = stat.cap_next ? S_FIN : S_LINK;
        end
      end
      S_FIN: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_sel  = OUT_FIN;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_SWEEP;
      clr_ack_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      clr_ack_r <= clr_ack_nxt;
    end
  end

endmodule

// File: hdl/lcns_dp.sv
module lcns_dp
  import lcns_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_wr_en,
  input  logic [IDX_W-1:0]         cfg_index,
  input  logic [CFG_W-1:0]         cfg_data,
  input  logic [1:0]               in_operation,
  input  logic [ITEM_W-1:0]        in_item_id,
  input  logic signed [POS_W-1:0]  in_pos_x,
  input  logic signed [POS_W-1:0]  in_pos_y,
  input  logic                     in_exclude_self,
  input  logic                     out_ready,
  output logic                     out_valid,
  output logic [ITEM_W-1:0]        out_neighbour_id,
  output logic                     out_found,
  output logic                     out_truncated,
  output logic                     out_last,
  input  lcns_cmd_t                cmd,
  output lcns_stat_t               stat
);

  // configuration
  logic signed [POS_W-1:0] org_x_r, org_y_r;
  logic [CS_W-1:0]  cell_size_r;
  logic [CNT_W-1:0] across_r, down_r;
  logic [R2_W-1:0]  r2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      org_x_r     <= '0;
      org_y_r     <= '0;
      cell_size_r <= 16'd256;
      across_r    <= 7'd64;
      down_r      <= 7'd64;
      r2_r        <= 32'd65536;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_ORIGIN_X:  org_x_r     <= cfg_data[POS_W-1:0];
        REG_ORIGIN_Y:  org_y_r     <= cfg_data[POS_W-1:0];
        REG_CELL_SIZE: cell_size_r <= cfg_data[CS_W-1:0];
        REG_ACROSS:    across_r    <= cfg_data[CNT_W-1:0];
        REG_DOWN:      down_r      <= cfg_data[CNT_W-1:0];
        REG_RADIUS_SQ: r2_r        <= cfg_data[R2_W-1:0];
        default: ;
      endcase
    end
  end

  logic [CNT_W-1:0] ncols, nrows;
  logic [CS_W-1:0]  cs;
  assign ncols = (across_r == '0) ? 7'd1 : ((across_r > MAX_COLS) ? MAX_COLS : across_r);
  assign nrows = (down_r == '0) ? 7'd1 : ((down_r > MAX_ROWS) ? MAX_ROWS : down_r);
  assign cs    = (cell_size_r == '0) ? 16'd1 : cell_size_r;

  // captured item
  logic [1:0]              op_r;
  logic [ITEM_W-1:0]       id_r;
  logic signed [POS_W-1:0] px_r, py_r;
  logic                    excl_r;

  // binning divider, one quotient bit per cycle for both axes
  logic signed [POS_W:0] offx, offy;
  logic [POS_W-1:0]  qx_r, qy_r;
  logic [CS_W-1:0]   remx_r, remy_r;
  logic              negx_r, negy_r;
  logic [DIV_CW-1:0] div_cnt_r;
  logic [CS_W:0]     shx, shy, difx, dify;
  logic              gex, gey;

  assign offx = POS_W'(0) + ({in_pos_x[POS_W-1], in_pos_x} - {org_x_r[POS_W-1], org_x_r});
  assign offy = POS_W'(0) + ({in_pos_y[POS_W-1], in_pos_y} - {org_y_r[POS_W-1], org_y_r});
  assign shx  = {remx_r, qx_r[POS_W-1]};
  assign shy  = {remy_r, qy_r[POS_W-1]};
  assign gex  = shx >= {1'b0, cs};
  assign gey  = shy >= {1'b0, cs};
  assign difx = shx - {1'b0, cs};
  assign dify = shy - {1'b0, cs};

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r   <= in_operation;
      id_r   <= in_item_id;
      px_r   <= in_pos_x;
      py_r   <= in_pos_y;
      excl_r <= in_exclude_self;
      negx_r <= offx[POS_W];
      negy_r <= offy[POS_W];
      qx_r   <= offx[POS_W-1:0];
      qy_r   <= offy[POS_W-1:0];
      remx_r <= '0;
      remy_r <= '0;
    end else if (cmd.div_step) begin
      remx_r <= gex ? difx[CS_W-1:0] : shx[CS_W-1:0];
      remy_r <= gey ? dify[CS_W-1:0] : shy[CS_W-1:0];
      qx_r   <= {qx_r[POS_W-2:0], gex};
      qy_r   <= {qy_r[POS_W-2:0], gey};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.load) begin
      div_cnt_r <= '0;
    end else if (cmd.div_step) begin
      div_cnt_r <= div_cnt_r + 5'd1;
    end
  end

  // cell iteration around the bin
  logic [COL_W-1:0] col_r, row_r, col_b, row_b;
  logic [1:0]       dc_r, dr_r;
  logic [CNT_W:0]   cc, rr;
  logic [CNT_W-1:0] ncm1, nrm1;

  assign ncm1  = ncols - 7'd1;
  assign nrm1  = nrows - 7'd1;
  assign col_b = negx_r ? '0 :
                 ((qx_r > {13'd0, ncm1}) ? ncm1[COL_W-1:0] : qx_r[COL_W-1:0]);
  assign row_b = negy_r ? '0 :
                 ((qy_r > {13'd0, nrm1}) ? nrm1[COL_W-1:0] : qy_r[COL_W-1:0]);
  assign cc = {2'b00, col_r} + {6'd0, dc_r} - 8'd1;
  assign rr = {2'b00, row_r} + {6'd0, dr_r} - 8'd1;

  always_ff @(posedge clk) begin
    if (cmd.bin) begin
      col_r <= col_b;
      row_r <= row_b;
      dc_r  <= (op_r == OP_INSERT) ? 2'd1 : 2'd0;
      dr_r  <= (op_r == OP_INSERT) ? 2'd1 : 2'd0;
    end else if (cmd.cell_next) begin
      if (dr_r == 2'd2) begin
        dr_r <= 2'd0;
        dc_r <= dc_r + 2'd1;
      end else begin
        dr_r <= dr_r + 2'd1;
      end
    end
  end

  // cell head memory, cleared by a sweep
  logic [ITEM_W:0]    head_mem [4096];
  logic [ITEM_W:0]    head_q;
  logic [CELL_W-1:0]  head_addr, sweep_r;

  assign head_addr = {rr[COL_W-1:0], cc[COL_W-1:0]};

  always_ff @(posedge clk) begin
    if (cmd.sweep) begin
      head_mem[sweep_r] <= '0;
    end else if (cmd.head_wr) begin
      head_mem[head_addr] <= {1'b1, id_r};
    end
    head_q <= head_mem[head_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sweep_r <= '0;
    end else if (cmd.sweep) begin
      sweep_r <= sweep_r + 12'd1;
    end
  end

  // per-item link and position memories
  logic [ITEM_W:0]         next_mem [1024];
  logic [POS_W-1:0]        sx_mem   [1024];
  logic [POS_W-1:0]        sy_mem   [1024];
  logic [ITEM_W:0]         next_q;
  logic signed [POS_W-1:0] sx_q, sy_q;
  logic [ITEM_W:0]         link_r;

  always_ff @(posedge clk) begin
    if (cmd.head_wr) begin
      next_mem[id_r] <= head_q;
      sx_mem[id_r]   <= px_r;
      sy_mem[id_r]   <= py_r;
    end
    next_q <= next_mem[link_r[ITEM_W-1:0]];
    sx_q   <= sx_mem[link_r[ITEM_W-1:0]];
    sy_q   <= sy_mem[link_r[ITEM_W-1:0]];
  end

  // list walk and distance test
  logic [STEP_W-1:0]         steps_r;
  logic [ITEM_W-1:0]         p_r;
  logic signed [POS_W:0]     dx, dy;
  logic signed [2*POS_W+1:0] dxsq_w, dysq_w;
  logic [2*POS_W+1:0]        dxsq_r, dysq_r;
  logic [2*POS_W+2:0]        d2;

  assign dx     = {sx_q[POS_W-1], sx_q} - {px_r[POS_W-1], px_r};
  assign dy     = {sy_q[POS_W-1], sy_q} - {py_r[POS_W-1], py_r};
  assign dxsq_w = dx * dx;
  assign dysq_w = dy * dy;
  assign d2     = {1'b0, dxsq_r} + {1'b0, dysq_r};

  always_ff @(posedge clk) begin
    if (cmd.head_load) begin
      link_r  <= head_q;
      steps_r <= '0;
    end else if (cmd.data_load) begin
      p_r     <= link_r[ITEM_W-1:0];
      link_r  <= next_q;
      steps_r <= steps_r + 11'd1;
      dxsq_r  <= dxsq_w;
      dysq_r  <= dysq_w;
    end
  end

  // hit collection: the latest hit waits until the next one or the end
  logic [NB_W-1:0]   count_r;
  logic              pend_v_r, trunc_r;
  logic [ITEM_W-1:0] pend_id_r;

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.load) begin
      count_r  <= '0;
      pend_v_r <= 1'b0;
      trunc_r  <= 1'b0;
    end else if (cmd.hit_take) begin
      count_r  <= count_r + 7'd1;
      pend_v_r <= 1'b1;
      trunc_r  <= (count_r == CAP_LAST);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.hit_take) begin
      pend_id_r <= p_r;
    end
  end

  // result register
  logic              out_valid_r;
  logic [ITEM_W-1:0] out_id_r;
  logic              out_found_r, out_trunc_r, out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      case (cmd.out_sel)
        OUT_PEND: begin
          out_id_r    <= pend_id_r;
          out_found_r <= 1'b1;
          out_trunc_r <= 1'b0;
          out_last_r  <= 1'b0;
        end
        OUT_FIN: begin
          out_id_r    <= pend_v_r ? pend_id_r : '0;
          out_found_r <= pend_v_r;
          out_trunc_r <= pend_v_r & trunc_r;
          out_last_r  <= 1'b1;
        end
        default: begin
          out_id_r    <= '0;
          out_found_r <= 1'b0;
          out_trunc_r <= 1'b0;
          out_last_r  <= 1'b1;
        end
      endcase
    end
  end

  assign out_valid        = out_valid_r;
  assign out_neighbour_id = out_id_r;
  assign out_found        = out_found_r;
  assign out_truncated    = out_trunc_r;
  assign out_last         = out_last_r;

  always_comb begin
    stat.sweep_done = (sweep_r == SWEEP_LAST);
    stat.div_last   = (div_cnt_r == DIV_LAST);
    stat.cell_ok    = !cc[CNT_W] && !rr[CNT_W] &&
                      (cc < {1'b0, ncols}) && (rr < {1'b0, nrows});
    stat.cell_last  = (dc_r == 2'd2) && (dr_r == 2'd2);
    stat.link_ok    = link_r[ITEM_W] && !steps_r[STEP_W-1];
    stat.hit        = (d2 < {11'd0, r2_r}) && !(excl_r && (p_r == id_r));
    stat.cap_next   = (count_r == CAP_LAST);
    stat.out_free   = !out_valid_r || out_ready;
    stat.pend_v     = pend_v_r;
    stat.op         = op_r;
  end

endmodule

// File: hdl/linked_cell_neighbour_search_top.sv
// Linked-cell neighbour search over a grid of up to 64 x 64 cells and 1024
// items. Operation clear empties the grid, insert bins a position into a cell
// and pushes the id onto that cell's list, query walks the 3x3 cells around
// the query position (columns outer, rows inner, each list from its head) and
// returns every stored id strictly inside radius_squared, at most 64, the
// final one marked last and, at the cap, truncated. Clear, insert and unused
// operations answer with one acknowledgement (found 0, last 1), as does a
// query without hits. After reset the cell table is swept before the first
// transfer is taken, and a clear runs the same sweep before its
// acknowledgement. Insert and query bin the position with a 20-step
// binning divider (one quotient bit per cycle for x and y); a query then
// visits each neighbour cell, reads the heads of those on the grid and
// walks their lists through the single read port of the link and position
// memories and a registered squaring stage. A waiting result stalls the walk
// only when another hit must be handed over.
module linked_cell_neighbour_search_top
  import lcns_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_wr_en,
  input  logic [IDX_W-1:0]        cfg_index,
  input  logic [CFG_W-1:0]        cfg_data,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [1:0]              in_operation,
  input  logic [ITEM_W-1:0]       in_item_id,
  input  logic signed [POS_W-1:0] in_pos_x,
  input  logic signed [POS_W-1:0] in_pos_y,
  input  logic                    in_exclude_self,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [ITEM_W-1:0]       out_neighbour_id,
  output logic                    out_found,
  output logic                    out_truncated,
  output logic                    out_last
);

  lcns_cmd_t  cmd;
  lcns_stat_t stat;

  // sequencer: sweep, binning, insert and walk steps
  lcns_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_operation (in_operation),
    .in_ready     (in_ready),
    .stat         (stat),
    .cmd          (cmd)
  );

  // registers, divider, memories, distance test and result register
  lcns_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_operation     (in_operation),
    .in_item_id       (in_item_id),
    .in_pos_x         (in_pos_x),
    .in_pos_y         (in_pos_y),
    .in_exclude_self  (in_exclude_self),
    .out_ready        (out_ready),
    .out_valid        (out_valid),
    .out_neighbour_id (out_neighbour_id),
    .out_found        (out_found),
    .out_truncated    (out_truncated),
    .out_last         (out_last),
    .cmd              (cmd),
    .stat             (stat)
  );

endmodule

// File: hdl/lcns_checker.sv
`include "linked_cell_neighbour_search_top_defines.svh"

module lcns_checker
  import lcns_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [ITEM_W-1:0] out_neighbour_id,
  input logic              out_found,
  input logic              out_truncated,
  input logic              out_last
);

  // a stalled result holds its payload
  `LCNS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_neighbour_id) && $stable(out_last))
  // acknowledgements carry a zero id and are always final
  `LCNS_ASSERT_NOW(a_ack_form, out_valid && !out_found, out_neighbour_id == '0 && out_last && !out_truncated)
  // truncation only marks the final hit
  `LCNS_ASSERT_NOW(a_trunc_last, out_valid && out_truncated, out_last && out_found)
  // reset leaves no result and takes no item
  `LCNS_ASSERT_RST(a_reset_quiet, !rst_n, !out_valid && !in_ready)

endmodule

bind linked_cell_neighbour_search_top lcns_checker u_lcns_checker (.*);
